/* design/pfim_pkg.sv */
// Shared types and constants for the packet field increment modifier.
`timescale 1ns / 1ps

package pfim_pkg;

    // Byte counter stops at this position; later bytes are never modified.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIELD_OFFSET = 3'd0,
        REG_FIELD_SIZE   = 3'd1,
        REG_BIT_START    = 3'd2,
        REG_BIT_LENGTH   = 3'd3,
        REG_START_VALUE  = 3'd4,
        REG_LIMIT_VALUE  = 3'd5,
        REG_STEP         = 3'd6
    } pfim_reg_idx_t;

    // Size code three selects no field in whole-field mode.
    typedef enum logic [1:0] {
        SIZE_ONE_BYTE  = 2'd0,
        SIZE_TWO_BYTES = 2'd1,
        SIZE_FOUR_BYTES = 2'd2,
        SIZE_NO_FIELD  = 2'd3
    } pfim_size_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_end;
    } pfim_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
    } pfim_out_t;

endpackage

/* design/packet_field_increment_modifier_core.sv */
// Top level of the packet field increment modifier.
`timescale 1ns / 1ps

// Packet bytes stream through one beat per cycle while the output side is not
// stalled. One field at a programmable byte offset is overwritten with a
// running value: a whole 1-, 2- or 4-byte big-endian field, or a bit field
// inside a 1- or 2-byte word counted from the MSB. The first packet after reset
// or after any register write carries the base value; the value advances by
// step at every packet end (whole fields wrap at their width, bit fields do
// not) and returns to base once it exceeds max. Rate is one byte per cycle
// while unstalled: the field insert and the 33-bit advance add/compare are
// combinational between the running-value state and the output register, and
// a skid register behind the output register lets a beat be taken while the
// previous result waits. Bytes at position MAX_FRAME_BYTES or later pass
// unchanged. Write configuration only while no beat is in flight.
module packet_field_increment_modifier_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  pfim_pkg::pfim_in_t                    in_data,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pfim_pkg::pfim_out_t                   out_data,

    input  logic                                  cfg_we,
    input  logic [pfim_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pfim_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_WHOLE,
        MODE_BITS
    } mode_t;

    // Configuration registers
    logic [10:0] field_offset_reg;
    logic [1:0]  field_size_reg;
    logic [3:0]  bit_start_reg;
    logic [4:0]  bit_length_reg;
    logic [31:0] start_value_reg;
    logic [31:0] limit_value_reg;
    logic [31:0] step_reg;

    // Running state
    logic [31:0]               current_value_reg;
    logic [31:0]               current_value_next;
    logic                      primed_reg;
    logic [pfim_pkg::POS_W-1:0] byte_position_reg;
    logic [pfim_pkg::POS_W-1:0] byte_position_next;

    // Output register and skid register
    logic                      out_valid_reg;
    pfim_pkg::pfim_out_t       out_data_reg;
    logic                      skid_valid_reg;
    pfim_pkg::pfim_out_t       skid_data_reg;

    logic accept;

    // Field geometry
    mode_t       mode;
    logic [31:0] fmask;
    logic [2:0]  nbytes;
    logic [4:0]  shift;
    logic        bit_word_two;
    logic [5:0]  bit_span;
    logic [5:0]  word_bits;
    logic [5:0]  shift_full;
    logic        bit_ok;
    logic [16:0] len_mask;

    // Datapath
    logic [31:0] prime_value;
    logic [31:0] cv_eff;
    logic [31:0] cv_masked;
    logic [31:0] word;
    logic [31:0] wmask;
    logic [pfim_pkg::POS_W-1:0] rel;
    logic        hit;
    logic [2:0]  byte_sel_full;
    logic [1:0]  byte_sel;
    logic [7:0]  mb;
    logic [7:0]  vb;
    logic [32:0] sum;
    logic [31:0] max_masked;
    logic [31:0] base_masked;
    logic [31:0] wrapped;
    pfim_pkg::pfim_out_t result;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Decode the field shape from the configuration.
    always_comb
    begin
        bit_word_two = (field_size_reg != pfim_pkg::SIZE_ONE_BYTE);
        bit_span     = {2'b00, bit_start_reg} + {1'b0, bit_length_reg};
        word_bits    = bit_word_two ? 6'd16 : 6'd8;
        bit_ok       = (bit_length_reg <= 5'd16) && (bit_span <= word_bits);
        len_mask     = (17'd1 << bit_length_reg) - 17'd1;
        shift_full   = word_bits - bit_span;

        mode   = MODE_NONE;
        fmask  = 32'd0;
        nbytes = 3'd0;
        shift  = 5'd0;
        if (bit_length_reg != 5'd0)
        begin
            if (bit_ok)
            begin
                mode   = MODE_BITS;
                fmask  = {16'd0, len_mask[15:0]};
                nbytes = bit_word_two ? 3'd2 : 3'd1;
                shift  = shift_full[4:0];
            end
        end
        else
        begin
            case (field_size_reg)
                pfim_pkg::SIZE_ONE_BYTE:
                begin
                    mode   = MODE_WHOLE;
                    fmask  = 32'h0000_00FF;
                    nbytes = 3'd1;
                end
                pfim_pkg::SIZE_TWO_BYTES:
                begin
                    mode   = MODE_WHOLE;
                    fmask  = 32'h0000_FFFF;
                    nbytes = 3'd2;
                end
                pfim_pkg::SIZE_FOUR_BYTES:
                begin
                    mode   = MODE_WHOLE;
                    fmask  = 32'hFFFF_FFFF;
                    nbytes = 3'd4;
                end
                default:
                begin
                    mode = MODE_NONE;
                end
            endcase
        end
    end

    // Insert the field and work out the next running value.
    always_comb
    begin
        base_masked = start_value_reg & fmask;
        max_masked  = limit_value_reg & fmask;
        prime_value = (mode != MODE_NONE) ? base_masked : start_value_reg;
        // Unprimed: this beat already uses base.
        cv_eff      = primed_reg ? current_value_reg : prime_value;
        cv_masked   = cv_eff & fmask;
        word        = cv_masked << shift;
        wmask       = fmask << shift;

        rel = byte_position_reg - {1'b0, field_offset_reg};
        hit = (mode != MODE_NONE)
              && (byte_position_reg < pfim_pkg::POS_W'(pfim_pkg::MAX_FRAME_BYTES))
              && (byte_position_reg >= {1'b0, field_offset_reg})
              && (rel < {{(pfim_pkg::POS_W-3){1'b0}}, nbytes});

        // Big-endian: first field byte is the most significant one.
        byte_sel_full = nbytes - 3'd1 - {1'b0, rel[1:0]};
        byte_sel      = byte_sel_full[1:0];
        mb            = wmask[{byte_sel, 3'b000} +: 8];
        vb            = word[{byte_sel, 3'b000} +: 8];

        result.out_end  = in_data.packet_end;
        result.out_byte = hit ? ((in_data.packet_byte & ~mb) | (vb & mb))
                              : in_data.packet_byte;

        sum     = {1'b0, cv_masked} + {1'b0, step_reg};
        wrapped = sum[31:0] & fmask;

        current_value_next = cv_eff;
        if (in_data.packet_end)
        begin
            case (mode)
                MODE_WHOLE:
                begin
                    current_value_next = (wrapped > max_masked) ? base_masked : wrapped;
                end
                MODE_BITS:
                begin
                    current_value_next = (sum > {1'b0, max_masked}) ? base_masked
                                                                     : sum[31:0];
                end
                default:
                begin
                    current_value_next = cv_eff;
                end
            endcase
        end

        if (in_data.packet_end)
        begin
            byte_position_next = '0;
        end
        else if (byte_position_reg < pfim_pkg::POS_W'(pfim_pkg::MAX_FRAME_BYTES))
        begin
            byte_position_next = byte_position_reg + 1'b1;
        end
        else
        begin
            byte_position_next = byte_position_reg;
        end
    end

    // Configuration and running state. A register write drops the primed
    // flag so the next beat reloads base.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_offset_reg  <= '0;
            field_size_reg    <= '0;
            bit_start_reg     <= '0;
            bit_length_reg    <= '0;
            start_value_reg   <= '0;
            limit_value_reg   <= 32'hFFFF_FFFF;
            step_reg          <= 32'd1;
            current_value_reg <= '0;
            primed_reg        <= 1'b0;
            byte_position_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                current_value_reg <= current_value_next;
                primed_reg        <= 1'b1;
                byte_position_reg <= byte_position_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pfim_pkg::REG_FIELD_OFFSET:
                    begin
                        field_offset_reg <= cfg_data[10:0];
                        primed_reg       <= 1'b0;
                    end
                    pfim_pkg::REG_FIELD_SIZE:
                    begin
                        field_size_reg <= cfg_data[1:0];
                        primed_reg     <= 1'b0;
                    end
                    pfim_pkg::REG_BIT_START:
                    begin
                        bit_start_reg <= cfg_data[3:0];
                        primed_reg    <= 1'b0;
                    end
                    pfim_pkg::REG_BIT_LENGTH:
                    begin
                        bit_length_reg <= cfg_data[4:0];
                        primed_reg     <= 1'b0;
                    end
                    pfim_pkg::REG_START_VALUE:
                    begin
                        start_value_reg <= cfg_data;
                        primed_reg      <= 1'b0;
                    end
                    pfim_pkg::REG_LIMIT_VALUE:
                    begin
                        limit_value_reg <= cfg_data;
                        primed_reg      <= 1'b0;
                    end
                    pfim_pkg::REG_STEP:
                    begin
                        step_reg   <= cfg_data;
                        primed_reg <= 1'b0;
                    end
                    default:
                    begin
                        // Unused index: drop the write.
                    end
                endcase
            end
        end
    end

    // Output register with skid: a stalled output parks the next beat in the
    // skid register, and the input holds off only while that is full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

`ifndef NO_ASSERTIONS
    // A parked beat always has a beat ahead of it in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    // The byte counter saturates at the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= pfim_pkg::POS_W'(pfim_pkg::MAX_FRAME_BYTES))
        else $error("byte position beyond frame limit");

    // A packet end restarts the byte count.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.packet_end |=> byte_position_reg == '0)
        else $error("byte position not cleared after packet end");

    // Any write to a defined register forces a reload of base.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index <= pfim_pkg::REG_STEP) |=> !primed_reg)
        else $error("register write did not clear primed flag");
`endif

endmodule
